@@ hdl/pu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking package
// Shared widths, the item record passed from front to back, and the constant
// factorial tables used for classification and for digit extraction.
// ----------------------------------------------------------------------------
package pu_pkg;

   localparam int SIZE_W      = 4;
   localparam int RANK_W      = 29;
   localparam int ELEM_W      = 4;
   localparam int MAX_N       = 12;
   localparam int QUEUE_DEPTH = 2;

   // Rows of the multiple table: one per factorial 0! to 11!.
   localparam int TBL         = 12;
   localparam int TBL_IDX_W   = 4;

   typedef struct packed {
      logic              bad;
      logic [SIZE_W-1:0] set_size;
      logic [RANK_W-1:0] zrank;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef logic [TBL-1:0][TBL-1:0][RANK_W-1:0] mult_table_type;

   function automatic logic [RANK_W-1:0] fact_of(input logic [SIZE_W-1:0] n);
      logic [RANK_W-1:0] f;
      begin
         case (n)
            4'd0:    f = RANK_W'(1);
            4'd1:    f = RANK_W'(1);
            4'd2:    f = RANK_W'(2);
            4'd3:    f = RANK_W'(6);
            4'd4:    f = RANK_W'(24);
            4'd5:    f = RANK_W'(120);
            4'd6:    f = RANK_W'(720);
            4'd7:    f = RANK_W'(5040);
            4'd8:    f = RANK_W'(40320);
            4'd9:    f = RANK_W'(362880);
            4'd10:   f = RANK_W'(3628800);
            4'd11:   f = RANK_W'(39916800);
            4'd12:   f = RANK_W'(479001600);
            default: f = '0;
         endcase
         return f;
      end
   endfunction

   // Entry [m][j] holds j * m!.
   function automatic mult_table_type build_mult_table();
      mult_table_type    t;
      logic [RANK_W-1:0] f;
      begin
         for (int m = 0; m < TBL; m++) begin
            f = fact_of(SIZE_W'(m));
            for (int j = 0; j < TBL; j++) begin
               t[m][j] = RANK_W'(64'(f) * 64'(j));
            end
         end
         return t;
      end
   endfunction

   localparam mult_table_type MULT_TABLE = build_mult_table();

endpackage

@@ hdl/pu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking front end
// Classifies an incoming item as servable or bad and makes the rank zero-based.
// ----------------------------------------------------------------------------
module pu_front #(
   parameter int MAX_N = pu_pkg::MAX_N
) (
   input  logic [pu_pkg::SIZE_W-1:0] req_set_size,
   input  logic [pu_pkg::RANK_W-1:0] req_rank,
   output pu_pkg::item_type          item
);

   logic bad;

   always_comb begin
      bad = (req_set_size == '0)
         || (req_set_size > pu_pkg::SIZE_W'(MAX_N))
         || (req_rank == '0)
         || (req_rank > pu_pkg::fact_of(req_set_size));
      item.bad      = bad;
      item.set_size = req_set_size;
      item.zrank    = req_rank - 1'b1;
   end

endmodule

@@ hdl/pu_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking item queue
// A short register FIFO that decouples the front end from the sequencer.
// ----------------------------------------------------------------------------
module pu_queue #(
   parameter int DEPTH = pu_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pu_pkg::item_type         push_item,
   input  logic                     pop,
   output pu_pkg::item_type         head_item,
   output pu_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pu_pkg::item_type  store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = store_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

@@ hdl/pu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking sequencer
// Extracts one factorial-base digit per cycle, picks and removes that element
// from the pool of unused values and emits it.
// ----------------------------------------------------------------------------
module pu_back #(
   parameter int MAX_N = pu_pkg::MAX_N
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pu_pkg::item_type                head_item,
   input  pu_pkg::queue_status_type        q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   output logic [pu_pkg::ELEM_W-1:0]       rsp_element,
   output logic                            rsp_last,
   output logic                            rsp_bad_rank
);

   localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CNT_W = $clog2(MAX_N + 1);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                      state_ff;
   logic [pu_pkg::RANK_W-1:0]      rank_ff;
   logic [pu_pkg::ELEM_W-1:0]      pool_ff [MAX_N];
   logic [CNT_W-1:0]               rem_ff;
   logic                           bad_ff;
   logic                           rsp_valid_ff;
   logic [pu_pkg::ELEM_W-1:0]      rsp_element_ff;
   logic                           rsp_last_ff;
   logic                           rsp_bad_rank_ff;

   logic [pu_pkg::TBL_IDX_W-1:0]   row;
   logic [IDX_W-1:0]               digit;
   logic [pu_pkg::ELEM_W-1:0]      chosen;
   logic                           finishing;

   always_comb begin
      row   = pu_pkg::TBL_IDX_W'(rem_ff - 1'b1);
      digit = '0;
      for (int j = 1; j < MAX_N; j++) begin
         if ((CNT_W'(j) < rem_ff) && (rank_ff >= pu_pkg::MULT_TABLE[row][j])) begin
            digit = IDX_W'(j);
         end
      end
      chosen    = pool_ff[digit];
      finishing = (state_ff == ST_RUN) && (bad_ff || (rem_ff == CNT_W'(1)));
      pop       = !q_status.empty && ((state_ff == ST_IDLE) || finishing);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_RUN);
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (finishing && !pop) begin
                  state_ff <= ST_IDLE;
               end
               if (bad_ff) begin
                  rsp_element_ff  <= '0;
                  rsp_last_ff     <= 1'b1;
                  rsp_bad_rank_ff <= 1'b1;
               end else begin
                  rsp_element_ff  <= chosen;
                  rsp_last_ff     <= (rem_ff == CNT_W'(1));
                  rsp_bad_rank_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (pop) begin
            bad_ff  <= head_item.bad;
            rank_ff <= head_item.zrank;
            rem_ff  <= CNT_W'(head_item.set_size);
            for (int i = 0; i < MAX_N; i++) begin
               pool_ff[i] <= pu_pkg::ELEM_W'(i + 1);
            end
         end else if ((state_ff == ST_RUN) && !bad_ff) begin
            rank_ff <= rank_ff
               - pu_pkg::MULT_TABLE[row][pu_pkg::TBL_IDX_W'(digit)];
            rem_ff  <= rem_ff - 1'b1;
            for (int i = 0; i < MAX_N - 1; i++) begin
               if (IDX_W'(i) >= digit) begin
                  pool_ff[i] <= pool_ff[i + 1];
               end
            end
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_bad_rank = rsp_bad_rank_ff;

endmodule

@@ hdl/permutation_unrank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking
// Emits the k-th lexicographic permutation of 1..n one element per cycle.
// ----------------------------------------------------------------------------
// An item is a set size and a one-based rank, presented on req_set_size and
// req_rank and taken at a clock edge where start is high and busy is low.
// Each result element appears on the rsp_ ports for one cycle with rsp_valid
// high; rsp_last marks the final element of the permutation. An item whose
// rank is zero, whose rank exceeds n factorial, or whose set size is zero or
// above MAX_N gives a single result with element zero, rsp_last and
// rsp_bad_rank set.
// A free sequencer loads a taken item from the queue, then registers its first
// element onto the rsp_ ports. A good item holds the sequencer until its last
// element, a bad one until its single result, one factorial-base digit being
// resolved per cycle against a constant multiple table; the next queued
// item loads as the last element is produced, so results stream without gaps.
// A two-entry queue lets further items be taken while one is in progress;
// busy is high only while that queue is full.
// Reset empties the queue and returns the sequencer to idle. Nothing is kept
// between items, and the receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
module permutation_unrank #(
   parameter int MAX_N       = pu_pkg::MAX_N,
   parameter int QUEUE_DEPTH = pu_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [pu_pkg::SIZE_W-1:0] req_set_size,
   input  logic [pu_pkg::RANK_W-1:0] req_rank,
   output logic                      rsp_valid,
   output logic [pu_pkg::ELEM_W-1:0] rsp_element,
   output logic                      rsp_last,
   output logic                      rsp_bad_rank
);

   pu_pkg::item_type         front_item;
   pu_pkg::item_type         head_item;
   pu_pkg::queue_status_type q_status;
   logic                     push;
   logic                     pop;

   assign busy = q_status.full;
   assign push = start && !busy;

   pu_front #(
      .MAX_N(MAX_N)
   ) u_front (
      .req_set_size(req_set_size),
      .req_rank    (req_rank),
      .item        (front_item)
   );

   pu_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(front_item),
      .pop      (pop),
      .head_item(head_item),
      .status   (q_status)
   );

   pu_back #(
      .MAX_N(MAX_N)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last),
      .rsp_bad_rank(rsp_bad_rank)
   );

`ifndef NO_ASSERTIONS
   a_bad_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_rank |-> rsp_last && (rsp_element == '0))
      else $error("bad rank result is not a single zero item");

   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_rank |-> (rsp_element != '0))
      else $error("good result carries element zero");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("permutation stream broken before its last element");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("sequencer took an item from an empty queue");
`endif

endmodule

@@ bench/unrank_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking checker
// Watches the request and result channels of the unranking block. For every
// item it takes, it works out the permutation that should follow and queues
// those elements. Each result strobe is compared with the oldest queued
// element, field by field. The failure count and the number of elements
// still awaited are handed back to the bench top.
// ----------------------------------------------------------------------------
module unrank_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [pu_pkg::SIZE_W-1:0] req_set_size,
   input  logic [pu_pkg::RANK_W-1:0] req_rank,
   input  logic                      rsp_valid,
   input  logic [pu_pkg::ELEM_W-1:0] rsp_element,
   input  logic                      rsp_last,
   input  logic                      rsp_bad_rank,
   output int                        fail_count,
   output int                        outstanding
);

   typedef struct packed {
      logic [pu_pkg::ELEM_W-1:0] element;
      logic                      last;
      logic                      bad_rank;
   } perm_elem_type;

   perm_elem_type awaited_elems[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic longint unsigned factorial(input int m);
      longint unsigned f;
      f = 1;
      for (int i = 2; i <= m; i++) begin
         f = f * longint'(i);
      end
      return f;
   endfunction

   function automatic void expand_permutation(input logic [pu_pkg::SIZE_W-1:0] n,
                                              input logic [pu_pkg::RANK_W-1:0] k);
      logic [pu_pkg::ELEM_W-1:0] pool[pu_pkg::MAX_N];
      longint unsigned           rem;
      longint unsigned           divisor;
      longint unsigned           digit;
      int                        left;
      int                        idx;
      perm_elem_type             e;
      if (n == 0 || n > pu_pkg::MAX_N || k == 0 || longint'(k) > factorial(n)) begin
         e.element  = '0;
         e.last     = 1'b1;
         e.bad_rank = 1'b1;
         awaited_elems = {awaited_elems, e};
         return;
      end
      for (int i = 0; i < pu_pkg::MAX_N; i++) begin
         pool[i] = pu_pkg::ELEM_W'(i + 1);
      end
      rem     = longint'(k) - 1;
      left    = int'(n);
      divisor = factorial(left - 1);
      while (left > 0) begin
         digit = rem / divisor;
         if (digit >= longint'(left)) begin
            digit = longint'(left - 1);
         end
         idx = int'(digit);
         e.element = pool[idx];
         for (int i = idx; i + 1 < left; i++) begin
            pool[i] = pool[i + 1];
         end
         left--;
         e.last     = (left == 0);
         e.bad_rank = 1'b0;
         awaited_elems = {awaited_elems, e};
         if (left == 0) begin
            break;
         end
         rem     = rem % divisor;
         divisor = divisor / longint'(left);
         if (divisor == 0) begin
            divisor = 1;
         end
      end
   endfunction

   always @(posedge clock) begin
      int            errs;
      perm_elem_type want;
      errs = 0;
      if (!reset) begin
         if (start && !busy) begin
            expand_permutation(req_set_size, req_rank);
         end
         if (rsp_valid) begin
            if (awaited_elems.size() == 0) begin
               $error("result element %0d with no item outstanding", rsp_element);
               errs++;
            end else begin
               want = awaited_elems.pop_front();
               if (rsp_element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp_element);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  errs++;
               end
               if (rsp_bad_rank !== want.bad_rank) begin
                  $error("bad_rank: expected %0d, got %0d", want.bad_rank, rsp_bad_rank);
                  errs++;
               end
            end
         end
      end
      fail_count  <= fail_count + errs;
      outstanding <= awaited_elems.size();
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation unranking bench
// Drives set sizes and ranks into the unranking block: a directed set of
// edge cases first, then random items with bursts of idle cycles, and a final
// stretch with start held high. The checker beside the block judges every
// result; this module gives the verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_ITEMS = 448;
   localparam int BURST_ITEMS  = 60;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [pu_pkg::RANK_W-1:0] RANK_MAX = '1;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [pu_pkg::SIZE_W-1:0] req_set_size;
   logic [pu_pkg::RANK_W-1:0] req_rank;
   logic                      rsp_valid;
   logic [pu_pkg::ELEM_W-1:0] rsp_element;
   logic                      rsp_last;
   logic                      rsp_bad_rank;
   int                        fail_count;
   int                        outstanding;
   int                        cycle_count;

   permutation_unrank DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_set_size (req_set_size),
      .req_rank     (req_rank),
      .rsp_valid    (rsp_valid),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_bad_rank (rsp_bad_rank)
   );

   unrank_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_set_size (req_set_size),
      .req_rank     (req_rank),
      .rsp_valid    (rsp_valid),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_bad_rank (rsp_bad_rank),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_set_size = '0;
      req_rank     = '0;
      cycle_count  = 0;
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned fact_limit(input int m);
      int unsigned f;
      f = 1;
      for (int i = 2; i <= m; i++) begin
         f = f * i;
      end
      return f;
   endfunction

   task automatic send_item(input logic [pu_pkg::SIZE_W-1:0] size,
                            input logic [pu_pkg::RANK_W-1:0] k,
                            input bit may_idle);
      int gap;
      @(negedge clock);
      req_set_size = size;
      req_rank     = k;
      start        = 1'b1;
      do @(posedge clock); while (busy);
      if (may_idle && $urandom_range(99) < 30) begin
         gap = $urandom_range(14, 1);
         @(negedge clock);
         start        = 1'b0;
         req_set_size = pu_pkg::SIZE_W'($urandom);
         req_rank     = pu_pkg::RANK_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_random(input bit may_idle);
      int                        kind;
      int                        n;
      int unsigned               top;
      logic [pu_pkg::SIZE_W-1:0] size;
      logic [pu_pkg::RANK_W-1:0] k;
      kind = $urandom_range(99);
      n    = $urandom_range(pu_pkg::MAX_N, 1);
      top  = fact_limit(n);
      size = pu_pkg::SIZE_W'(n);
      if (kind < 6) begin
         k = '0;
      end else if (kind < 13) begin
         k = pu_pkg::RANK_W'($urandom_range(RANK_MAX, top + 1));
      end else if (kind < 17) begin
         size = ($urandom_range(1) == 0) ? '0
                : pu_pkg::SIZE_W'($urandom_range(15, pu_pkg::MAX_N + 1));
         k    = pu_pkg::RANK_W'($urandom);
      end else if (kind < 22) begin
         k = ($urandom_range(1) == 0) ? pu_pkg::RANK_W'(1) : pu_pkg::RANK_W'(top);
      end else begin
         k = pu_pkg::RANK_W'($urandom_range(top, 1));
      end
      send_item(size, k, may_idle);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(4'd1, pu_pkg::RANK_W'(1), 1'b1);
      send_item(4'd1, pu_pkg::RANK_W'(0), 1'b1);
      send_item(4'd1, pu_pkg::RANK_W'(2), 1'b1);
      send_item(4'd0, pu_pkg::RANK_W'(1), 1'b1);
      send_item(4'd13, pu_pkg::RANK_W'(1), 1'b1);
      send_item(4'd15, RANK_MAX, 1'b1);
      send_item(4'd12, pu_pkg::RANK_W'(1), 1'b1);
      send_item(4'd12, pu_pkg::RANK_W'(479001600), 1'b1);
      send_item(4'd12, pu_pkg::RANK_W'(479001601), 1'b1);
      send_item(4'd12, RANK_MAX, 1'b1);
      send_item(4'd12, pu_pkg::RANK_W'(268435456), 1'b1);
      for (int k = 1; k <= 6; k++) begin
         send_item(4'd3, pu_pkg::RANK_W'(k), 1'b1);
      end
      send_item(4'd2, pu_pkg::RANK_W'(2), 1'b1);
      send_item(4'd2, pu_pkg::RANK_W'(3), 1'b1);
      send_item(4'd4, pu_pkg::RANK_W'(24), 1'b1);
      send_item(4'd11, pu_pkg::RANK_W'(39916800), 1'b1);
      send_item(4'd11, pu_pkg::RANK_W'(39916801), 1'b1);
      send_item(4'd7, pu_pkg::RANK_W'(2521), 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_random(i < RANDOM_ITEMS - BURST_ITEMS);
      end
      @(negedge clock);
      start = 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
